[hw/rtl/utc_pkg.sv]
// Package: shared constants, types and helpers for the UTF-8 text classifier.
package utc_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int CFG_BITS = 32;
	localparam logic [CFG_BITS-1:0] LEN_LIMIT_RESET = 32'd65536;

	localparam int BYTE_BITS = 8;
	localparam int CP_BITS = 21;
	localparam int OUT_TDATA_BITS = 8;

	localparam logic [CP_BITS-1:0] CP_MAX = 21'h10FFFF;
	localparam logic [CP_BITS-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_BITS-1:0] CP_SURR_LO = 21'h00D800;
	localparam logic [CP_BITS-1:0] CP_SURR_HI = 21'h00DFFF;
	localparam logic [CP_BITS-1:0] CP_MIN_2B = 21'h000080;
	localparam logic [CP_BITS-1:0] CP_MIN_3B = 21'h000800;
	localparam logic [CP_BITS-1:0] CP_MIN_4B = 21'h010000;

	localparam logic [BYTE_BITS-1:0] CTRL_LIMIT = 8'h20;
	localparam logic [BYTE_BITS-1:0] CHAR_TAB = 8'h09;
	localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0A;
	localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0D;

	typedef enum logic [2:0] {
		VERDICT_TEXT     = 3'd0,
		VERDICT_EMPTY    = 3'd1,
		VERDICT_TOO_LONG = 3'd2,
		VERDICT_INVALID  = 3'd3,
		VERDICT_CONTROLS = 3'd4
	} verdict_t;

	// per-transaction step control shared by the state blocks
	typedef struct packed {
		logic en;
		logic has_byte;
		logic last;
	} step_t;

	function automatic logic is_control(input logic [BYTE_BITS-1:0] b);
		return (b < CTRL_LIMIT) && (b != CHAR_TAB) && (b != CHAR_LF) && (b != CHAR_CR);
	endfunction

endpackage

[hw/rtl/utf8_text_classifier_unit.sv]
// Top level: byte-stream UTF-8 validator and plain-text classifier.
//
//  channel | signals                          | payload
//  --------+----------------------------------+--------------------------------------
//  cfg     | cfg_we, cfg_wdata                | len_limit[31:0]
//  in      | s_tvalid, s_tready, s_tlast/tuser| tdata: data_byte; tuser: no_byte
//  out     | m_tvalid, m_tready               | tdata: is_text, utf8_valid, verdict
//
// One byte per cycle unless a stalled result holds a last transaction: a transaction is
// registered in the input register, then decoded and counted from there, and its verdict is
// registered in the output register.
// Reset clears all string state and loads the length limit with 65536.
// A stalled result holds the input only once the next last transaction
// reaches the input register; bytes ahead of it flow.
module utf8_text_classifier_unit
	import utc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_BITS-1:0]       cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [BYTE_BITS-1:0]      s_tdata,  // [7:0] data_byte
	input  logic                      s_tlast,  // last_byte
	input  logic                      s_tuser,  // no_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata   // [0] is_text, [1] utf8_valid, [4:2] verdict
);

	localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

	logic [CFG_BITS-1:0]       len_limit_q;
	logic                      in_valid_s1;
	logic [BYTE_BITS-1:0]      in_byte_s1;
	logic                      in_last_s1;
	logic                      in_none_s1;
	logic                      adv;
	step_t                     step;
	logic                      valid_next;
	logic [COUNT_BITS-1:0]     byte_next, ctrl_next;
	logic                      exceed_next;
	verdict_t                  verdict;
	logic                      out_valid_q;
	logic [OUT_TDATA_BITS-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit_q <= LEN_LIMIT_RESET;
		end else if (cfg_we) begin
			len_limit_q <= cfg_wdata;
		end
	end

	assign adv = in_valid_s1 && (!in_last_s1 || !out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
			in_none_s1 <= s_tuser;
		end
	end

	assign step = '{en: adv, has_byte: adv && !in_none_s1, last: in_last_s1};

	utc_utf8_decoder u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (in_byte_s1),
		.valid_next (valid_next)
	);

	utc_length_counter #(
		.COUNT_BITS (COUNT_BITS)
	) u_cnt (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (in_byte_s1),
		.byte_next   (byte_next),
		.ctrl_next   (ctrl_next),
		.exceed_next (exceed_next)
	);

	always_comb begin
		if (byte_next == '0 && !exceed_next) begin
			verdict = VERDICT_EMPTY;
		end else if (exceed_next || CMP_BITS'(byte_next) > CMP_BITS'(len_limit_q)) begin
			verdict = VERDICT_TOO_LONG;
		end else if (!valid_next) begin
			verdict = VERDICT_INVALID;
		end else if (ctrl_next > (byte_next >> 2)) begin
			verdict = VERDICT_CONTROLS;
		end else begin
			verdict = VERDICT_TEXT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && in_last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_last_s1) begin
			out_data_q <= {3'b000, verdict, valid_next, verdict == VERDICT_TEXT};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

[hw/rtl/utc_utf8_decoder.sv]
// Strict UTF-8 decoder state and its single-step update.
module utc_utf8_decoder
	import utc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  step_t                step,
	input  logic [BYTE_BITS-1:0] data_byte,
	output logic                 valid_next
);

	logic [1:0]         pend_q, pend_n;
	logic [1:0]         wid_q, wid_n;
	logic [CP_BITS-1:0] cp_q, cp_n;
	logic               err_q, err_n;

	always_comb begin
		pend_n = pend_q;
		wid_n = wid_q;
		cp_n = cp_q;
		err_n = err_q;
		if (step.has_byte && !err_q) begin
			if (pend_q == 2'd0) begin
				if (data_byte == '0) begin
					err_n = 1'b1;
				end else if (!data_byte[7]) begin
					err_n = 1'b0;
				end else if (data_byte[7:5] == 3'b110) begin
					cp_n = {16'd0, data_byte[4:0]};
					if (data_byte[4:0] == 5'd0) begin
						err_n = 1'b1;
					end else begin
						wid_n = 2'd1;
						pend_n = 2'd1;
					end
				end else if (data_byte[7:4] == 4'b1110) begin
					cp_n = {17'd0, data_byte[3:0]};
					wid_n = 2'd2;
					pend_n = 2'd2;
				end else if (data_byte[7:3] == 5'b11110) begin
					cp_n = {18'd0, data_byte[2:0]};
					wid_n = 2'd3;
					pend_n = 2'd3;
				end else begin
					err_n = 1'b1;
				end
			end else if (data_byte[7:6] != 2'b10) begin
				err_n = 1'b1;
				pend_n = 2'd0;
			end else begin
				cp_n = {cp_q[CP_BITS-7:0], data_byte[5:0]};
				pend_n = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					if ((wid_q == 2'd1 && cp_n < CP_MIN_2B) ||
					    (wid_q == 2'd2 && cp_n < CP_MIN_3B) ||
					    (wid_q == 2'd3 && cp_n < CP_MIN_4B) ||
					    cp_n > CP_MAX ||
					    (cp_n >= CP_SURR_LO && cp_n <= CP_SURR_HI) ||
					    cp_n == CP_REPLACEMENT) begin
						err_n = 1'b1;
					end
				end
			end
		end
	end

	assign valid_next = !err_n && (pend_n == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			wid_q <= '0;
			cp_q <= '0;
			err_q <= 1'b0;
		end else if (step.en) begin
			if (step.last) begin
				pend_q <= '0;
				wid_q <= '0;
				cp_q <= '0;
				err_q <= 1'b0;
			end else begin
				pend_q <= pend_n;
				wid_q <= wid_n;
				cp_q <= cp_n;
				err_q <= err_n;
			end
		end
	end

endmodule

[hw/rtl/utc_length_counter.sv]
// Saturating byte and control-byte counters with the overlength flag.
module utc_length_counter
	import utc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  step_t                 step,
	input  logic [BYTE_BITS-1:0]  data_byte,
	output logic [COUNT_BITS-1:0] byte_next,
	output logic [COUNT_BITS-1:0] ctrl_next,
	output logic                  exceed_next
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] byte_q, ctrl_q;
	logic                  exceed_q;

	always_comb begin
		byte_next = byte_q;
		ctrl_next = ctrl_q;
		exceed_next = exceed_q;
		if (step.has_byte) begin
			if (byte_q == CNT_MAX) begin
				exceed_next = 1'b1;
			end else begin
				byte_next = byte_q + COUNT_BITS'(1);
			end
			if (is_control(data_byte) && ctrl_q != CNT_MAX) begin
				ctrl_next = ctrl_q + COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			ctrl_q <= '0;
			exceed_q <= 1'b0;
		end else if (step.en) begin
			if (step.last) begin
				byte_q <= '0;
				ctrl_q <= '0;
				exceed_q <= 1'b0;
			end else begin
				byte_q <= byte_next;
				ctrl_q <= ctrl_next;
				exceed_q <= exceed_next;
			end
		end
	end

endmodule

[hw/rtl/utc_checker.sv]
// Port-level checker for the UTF-8 text classifier, bound to the top level.
module utc_checker
	import utc_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [OUT_TDATA_BITS-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_is_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[4:2] == VERDICT_TEXT)))
		else $error("is_text disagrees with verdict");

	a_text_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[4:2] == VERDICT_TEXT || m_tdata[4:2] == VERDICT_EMPTY ||
		             m_tdata[4:2] == VERDICT_CONTROLS) |-> m_tdata[1])
		else $error("verdict past the encoding check without valid UTF-8");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:2] == VERDICT_INVALID |-> !m_tdata[1])
		else $error("invalid verdict with valid UTF-8");

endmodule

bind utf8_text_classifier_unit utc_checker u_utc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[test/utc_verdict_checker.sv]
// Checker for the UTF-8 text classifier: predicts each verdict and compares it with the result.
`timescale 1ns / 1ps
module utc_verdict_checker
	import utc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_BITS-1:0]       cfg_wdata,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [BYTE_BITS-1:0]      s_tdata,  // [7:0] data_byte
	input  logic                      s_tlast,  // last_byte
	input  logic                      s_tuser,  // no_byte
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [OUT_TDATA_BITS-1:0] m_tdata,  // [0] is_text, [1] utf8_valid, [4:2] verdict
	output int                        mismatch_count,
	output int                        results_owed
);

	localparam int CNT_W = COUNT_BITS_DEF;

	typedef struct packed {
		logic     is_text;
		logic     utf8_ok;
		verdict_t verdict;
	} verdict_rec_t;

	verdict_rec_t verdict_q[$];

	logic [1:0]          cont_left;
	logic [1:0]          seq_len;
	logic [CP_BITS-1:0]  cp_acc;
	logic                enc_err;
	logic [CNT_W-1:0]    byte_cnt;
	logic [CNT_W-1:0]    ctrl_cnt;
	logic                len_over;
	logic [CFG_BITS-1:0] max_len;

	task automatic clear_string();
		cont_left = 2'd0;
		seq_len = 2'd0;
		cp_acc = '0;
		enc_err = 1'b0;
		byte_cnt = '0;
		ctrl_cnt = '0;
		len_over = 1'b0;
	endtask

	task automatic decode_byte(input logic [BYTE_BITS-1:0] b);
		if (!enc_err) begin
			if (cont_left == 2'd0) begin
				casez (b)
					8'b110?_????: begin
						cp_acc = {16'd0, b[4:0]};
						if (b[4:0] == 5'd0) begin
							enc_err = 1'b1;
						end else begin
							seq_len = 2'd1;
							cont_left = 2'd1;
						end
					end
					8'b1110_????: begin
						cp_acc = {17'd0, b[3:0]};
						seq_len = 2'd2;
						cont_left = 2'd2;
					end
					8'b1111_0???: begin
						cp_acc = {18'd0, b[2:0]};
						seq_len = 2'd3;
						cont_left = 2'd3;
					end
					8'h00, 8'b10??_????, 8'b1111_1???: enc_err = 1'b1;
					default: ;
				endcase
			end else if (b[7:6] != 2'b10) begin
				// a broken sequence is not reread as a lead byte
				enc_err = 1'b1;
				cont_left = 2'd0;
			end else begin
				cp_acc = {cp_acc[CP_BITS-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0 &&
						((seq_len == 2'd1 && cp_acc < CP_MIN_2B) ||
						 (seq_len == 2'd2 && cp_acc < CP_MIN_3B) ||
						 (seq_len == 2'd3 && cp_acc < CP_MIN_4B) ||
						 cp_acc > CP_MAX ||
						 (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI) ||
						 cp_acc == CP_REPLACEMENT))
					enc_err = 1'b1;
			end
		end
	endtask

	task automatic take_byte(input logic [BYTE_BITS-1:0] b);
		if (byte_cnt == '1)
			len_over = 1'b1;
		else
			byte_cnt = byte_cnt + CNT_W'(1);
		if (b < CTRL_LIMIT && b != CHAR_TAB && b != CHAR_LF && b != CHAR_CR && ctrl_cnt != '1)
			ctrl_cnt = ctrl_cnt + CNT_W'(1);
		decode_byte(b);
	endtask

	task automatic close_string();
		verdict_rec_t rec;
		rec.utf8_ok = !enc_err && cont_left == 2'd0;
		if (byte_cnt == '0 && !len_over)
			rec.verdict = VERDICT_EMPTY;
		else if (len_over || byte_cnt > max_len)
			rec.verdict = VERDICT_TOO_LONG;
		else if (!rec.utf8_ok)
			rec.verdict = VERDICT_INVALID;
		else if (ctrl_cnt > (byte_cnt >> 2))
			rec.verdict = VERDICT_CONTROLS;
		else
			rec.verdict = VERDICT_TEXT;
		rec.is_text = rec.verdict == VERDICT_TEXT;
		verdict_q.insert(verdict_q.size(), rec);
		clear_string();
	endtask

	task automatic check_result();
		verdict_rec_t want;
		if (verdict_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: result with nothing expected, tdata=%h", $time, m_tdata);
		end else begin
			want = verdict_q.pop_front();
			if (m_tdata[0] !== want.is_text || m_tdata[1] !== want.utf8_ok ||
					m_tdata[4:2] !== want.verdict) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: expected is_text=%0b utf8_valid=%0b verdict=%0d, %s%0b %s%0b %s%0d",
						$time, want.is_text, want.utf8_ok, want.verdict,
						"got is_text=", m_tdata[0], "utf8_valid=", m_tdata[1],
						"verdict=", m_tdata[4:2]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len = LEN_LIMIT_RESET;
			clear_string();
			verdict_q.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_we)
				max_len = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (!s_tuser)
					take_byte(s_tdata);
				if (s_tlast)
					close_string();
			end
		end
		results_owed = verdict_q.size();
	end

endmodule

[test/tb_utf8_text_classifier_unit.sv]
// Testbench top for the UTF-8 text classifier: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_utf8_text_classifier_unit;
	import utc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 105;

	// {no_byte, last_byte, data_byte}
	localparam logic [9:0] DIRECTED [26] = '{
		10'h300,
		10'h041, 10'h200, 10'h300,
		10'h100,
		10'h0C1, 10'h181,
		10'h0ED, 10'h0A0, 10'h180,
		10'h0EF, 10'h0BF, 10'h1BD,
		10'h0F4, 10'h090, 10'h080, 10'h180,
		10'h0E2, 10'h041, 10'h182,
		10'h101,
		10'h1FF,
		10'h1C3,
		10'h0C3, 10'h0A9, 10'h109
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_BITS-1:0]       cfg_wdata = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [BYTE_BITS-1:0]      s_tdata = '0;
	logic                      s_tlast = 1'b0;
	logic                      s_tuser = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;

	int mismatch_count;
	int results_owed;
	int quiet_cycles = 0;
	int items_sent = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	logic [7:0] text_bytes[$];

	utf8_text_classifier_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	utc_verdict_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.mismatch_count(mismatch_count),
		.results_owed  (results_owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last, input logic none);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		s_tuser <= none;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (last || !none)
			items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_len_limit(input logic [CFG_BITS-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endtask

	task automatic put_cp(input logic [20:0] cp, input int n);
		case (n)
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic put_char(input bit clean, input bit heavy);
		int kind;
		int n;
		int k;
		logic [7:0] r;
		kind = heavy ? $urandom_range(0, 49) :
			clean ? $urandom_range(0, 79) : $urandom_range(0, 99);
		n = $urandom_range(2, 4);
		if (kind < 40) begin
			if (heavy && $urandom_range(0, 1) == 1)
				r = 8'($urandom_range(1, 31));
			else
				r = 8'($urandom_range(32, 127));
			add_byte(r);
		end else if (kind < 55) begin
			put_cp(21'($urandom_range(21'h80, 21'h7FF)), 2);
		end else if (kind < 70) begin
			put_cp(21'($urandom_range(21'h800, 21'hFFFF)), 3);
		end else if (kind < 80) begin
			put_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
		end else if (kind < 83) begin
			// overlong
			put_cp(21'(n == 2 ? $urandom_range(0, 21'h7F) :
				n == 3 ? $urandom_range(0, 21'h7FF) : $urandom_range(0, 21'hFFFF)), n);
		end else if (kind < 85) begin
			put_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
		end else if (kind < 87) begin
			put_cp(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
		end else if (kind < 88) begin
			put_cp(CP_REPLACEMENT, 3);
		end else if (kind < 91) begin
			// bad continuation byte
			put_cp(21'($urandom_range(21'h1000, 21'hCFFF)), 3);
			k = text_bytes.size() - $urandom_range(1, 2);
			r = 8'($urandom_range(0, 255));
			if (r[7:6] == 2'b10)
				r[6] = 1'b1;
			text_bytes[k] = r;
		end else if (kind < 94) begin
			// sequence cut short
			put_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
			repeat ($urandom_range(1, 3))
				r = text_bytes.pop_back();
		end else if (kind < 97) begin
			add_byte(8'($urandom_range(0, 255)));
		end else begin
			add_byte($urandom_range(0, 1) == 1 ? 8'h00 : 8'hFF);
		end
	endtask

	task automatic send_string();
		int nchar;
		bit clean;
		bit heavy;
		bit none_tail;
		text_bytes.delete();
		clean = $urandom_range(0, 9) < 6;
		heavy = $urandom_range(0, 5) == 0;
		nchar = $urandom_range(1, 8);
		if ($urandom_range(0, 24) == 0)
			nchar = 0;
		else if ($urandom_range(0, 24) == 0)
			nchar = $urandom_range(12, 30);
		repeat (nchar)
			put_char(clean, heavy);
		none_tail = text_bytes.size() == 0 || $urandom_range(0, 5) == 0;
		foreach (text_bytes[i]) begin
			if ($urandom_range(0, 19) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			send_item(text_bytes[i], !none_tail && i == text_bytes.size() - 1, 1'b0);
		end
		if (none_tail)
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	initial begin
		int phase;
		int stop_at;
		bit held;
		logic [CFG_BITS-1:0] limit;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			send_item(DIRECTED[i][7:0], DIRECTED[i][8], DIRECTED[i][9]);
		drain();
		for (phase = 0; phase < 6; phase++) begin
			case (phase % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 83; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 83; end
				default: begin gap_pct = 21; stall_pct = 21; end
			endcase
			case (phase)
				0: limit = 32'd8;
				1: limit = 32'd0;
				2: limit = 32'hFFFF_FFFF;
				3: limit = CFG_BITS'($urandom_range(2, 40));
				4: limit = 32'd1;
				default: limit = $urandom;
			endcase
			write_len_limit(limit);
			stop_at = items_sent + PHASE_ITEMS;
			held = 1'b0;
			while (items_sent < stop_at) begin
				send_string();
				if (!held && items_sent > stop_at - PHASE_ITEMS / 2) begin
					drain();
					held = 1'b1;
				end
			end
			drain();
		end
		if (mismatch_count == 0 && results_owed == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
